// ===== hw/rtl/cubic_bezier_segment_eval_macros.svh =====
// Assertion macros for the cubic Bezier segment evaluator.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef CUBIC_BEZIER_SEGMENT_EVAL_MACROS_SVH
`define CUBIC_BEZIER_SEGMENT_EVAL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CBZ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CBZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbz_pkg.sv =====
// Shared types and constants for the cubic Bezier segment evaluator.
// No dependencies; imported by cbz_mul, cubic_bezier_segment_eval and the testbench.
`timescale 1ns / 1ps

package cbz_pkg;

    // fixed field widths of the word format
    localparam int POINT_INDEX_W = 6;
    localparam int SEG_W         = 4;
    localparam int COUNT_W       = 7;

    // op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // basis schedule slots on the shared multiplier
    localparam logic [2:0] STEP_UU  = 3'd0;
    localparam logic [2:0] STEP_TT  = 3'd1;
    localparam logic [2:0] STEP_U2U = 3'd2;
    localparam logic [2:0] STEP_TU2 = 3'd3;
    localparam logic [2:0] STEP_T2U = 3'd4;
    localparam logic [2:0] STEP_T2T = 3'd5;

    localparam logic [1:0] AXIS_LAST  = 2'd2;
    localparam logic [1:0] POINT_LAST = 2'd3;

    // what the product register holds
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_U2   = 3'd1,
        KIND_T2   = 3'd2,
        KIND_B0   = 3'd3,
        KIND_B1   = 3'd4,
        KIND_B2   = 3'd5,
        KIND_B3   = 3'd6,
        KIND_ACC  = 3'd7
    } prod_kind_t;

    typedef struct packed {
        prod_kind_t kind;
        logic [1:0] axis;
    } mul_tag_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BASIS = 6'b000010,
        ST_DOT   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// ===== hw/rtl/cbz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cbz_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== hw/rtl/cbz_mul.sv =====
// Shared signed multiplier with a registered product and a tag that travels with it.
// Depends on cbz_pkg (mul_tag_t).
`timescale 1ns / 1ps

module cbz_mul import cbz_pkg::*; #(
    parameter int A_WIDTH = 18,
    parameter int B_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [A_WIDTH-1:0]         op_a,
    input  logic signed [B_WIDTH-1:0]         op_b,
    input  mul_tag_t                          tag_in,
    output logic signed [A_WIDTH+B_WIDTH-1:0] prod_reg,
    output mul_tag_t                          tag_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '{kind: KIND_NONE, axis: '0};
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

endmodule

// ===== hw/rtl/cubic_bezier_segment_eval.sv =====
// Cubic Bezier segment evaluator: control point store, sequencer, shared multiplier.
// Depends on cbz_pkg, cbz_ram, cbz_mul and cubic_bezier_segment_eval_macros.svh.
`timescale 1ns / 1ps
`include "cubic_bezier_segment_eval_macros.svh"

//  channel  | handshake             | word
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | op, point_index, point_x/y/z, seg_index, t_frac
//  out      | out_valid / out_stall | target_x/y/z, updated
//  cfg      | cfg_we                | cfg_wdata -> point_count
//
// A write word is accepted in idle and leaves the sequencer there. A live evaluate runs
// 6 basis products and 12 coordinate products, one per cycle on the shared multiplier,
// then drain, saturate and output load into the result register, then returns to idle.
// A missing segment goes straight to the output load, then back to idle. Input
// stalls outside idle; a result blocked by a full output register holds the sequencer.
// Reset clears the held target, point_count and control; the point store is not cleared.

module cubic_bezier_segment_eval import cbz_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [COUNT_W-1:0]              cfg_wdata,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [POINT_INDEX_W-1:0]        point_index,
    input  logic signed [COORD_WIDTH-1:0]   point_x,
    input  logic signed [COORD_WIDTH-1:0]   point_y,
    input  logic signed [COORD_WIDTH-1:0]   point_z,
    input  logic [SEG_W-1:0]                seg_index,
    input  logic [FRAC_BITS-1:0]            t_frac,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [COORD_WIDTH-1:0]   target_x,
    output logic signed [COORD_WIDTH-1:0]   target_y,
    output logic signed [COORD_WIDTH-1:0]   target_z,
    output logic                            updated
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int BW   = F + 1;                      // basis values, 0 .. 2^F
    localparam int MA   = F + 2;                      // multiplier A operand, signed
    localparam int MB   = (CW > F + 2) ? CW : F + 2;  // multiplier B operand, signed
    localparam int PW   = MA + MB;
    localparam int ACCW = F + CW + 2;

    // ---------------------------------------------------------------
    // control and datapath registers
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [1:0]             k_reg, k_next;
    logic [1:0]             ax_reg, ax_next;
    logic [COUNT_W-1:0]     count_reg;

    logic [F-1:0]           t_reg;
    logic [AW-1:0]          base_reg;
    logic                   upd_reg;
    logic [BW-1:0]          u2_reg;
    logic [BW-1:0]          t2_reg;
    logic [BW-1:0]          b_reg [4];
    logic signed [ACCW-1:0] acc_reg [3];
    logic signed [CW-1:0]   held_reg [3];

    logic                   out_valid_reg;
    logic signed [CW-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                   out_upd_reg;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic                   in_acc;
    logic                   eval_acc;
    logic [COUNT_W-1:0]     seg_end;
    logic                   seg_ok;
    logic [31:0]            base_ext;
    logic [31:0]            idx_ext;
    logic                   wr_en;
    logic                   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign eval_acc = in_acc && (op == OP_EVAL);

    // segment needs slots 4s .. 4s+3 under both point_count and the store depth
    assign seg_end  = COUNT_W'({seg_index, 2'b00}) + COUNT_W'(4);
    assign seg_ok   = (seg_end <= count_reg) && (32'(seg_end) <= 32'(MAX_POINTS));
    assign base_ext = 32'({seg_index, 2'b00});
    assign idx_ext  = 32'(point_index);
    assign wr_en    = in_acc && (op == OP_WRITE) && (idx_ext < 32'(MAX_POINTS));

    assign out_free = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------
    // point store
    // ---------------------------------------------------------------
    logic [1:0]          k_rd;
    logic [AW-1:0]       rd_addr;
    logic [3*CW-1:0]     rd_data;
    logic signed [CW-1:0] rd_coord;

    // address runs one point ahead so the registered read lines up with the operand select
    assign k_rd    = (state_reg == ST_DOT && ax_reg == AXIS_LAST) ? k_reg + 2'd1 : k_reg;
    assign rd_addr = base_reg + AW'(k_rd);

    cbz_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk       (clk),
        .we        (wr_en),
        .waddr     (idx_ext[AW-1:0]),
        .wdata     ({point_z, point_y, point_x}),
        .raddr     (rd_addr),
        .rdata_reg (rd_data)
    );

    always_comb
    begin
        case (ax_reg)
            2'd0:    rd_coord = rd_data[CW-1:0];
            2'd1:    rd_coord = rd_data[2*CW-1:CW];
            default: rd_coord = rd_data[3*CW-1:2*CW];
        endcase
    end

    // ---------------------------------------------------------------
    // shared multiplier and operand select
    // ---------------------------------------------------------------
    logic [BW-1:0]        u_val;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    mul_tag_t             mul_tag_in;
    logic signed [PW-1:0] prod;
    mul_tag_t             prod_tag;
    logic [BW-1:0]        prod_shr;
    logic [BW+1:0]        prod_x3;

    assign u_val = (BW'(1) << F) - BW'(t_reg);

    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        mul_tag_in = '{kind: KIND_NONE, axis: '0};
        if (state_reg == ST_BASIS)
        begin
            case (step_reg)
                STEP_UU:
                begin
                    mul_a = MA'(u_val);
                    mul_b = MB'(u_val);
                    mul_tag_in.kind = KIND_U2;
                end
                STEP_TT:
                begin
                    mul_a = MA'(t_reg);
                    mul_b = MB'(t_reg);
                    mul_tag_in.kind = KIND_T2;
                end
                STEP_U2U:
                begin
                    mul_a = MA'(u2_reg);
                    mul_b = MB'(u_val);
                    mul_tag_in.kind = KIND_B0;
                end
                STEP_TU2:
                begin
                    mul_a = MA'(t_reg);
                    mul_b = MB'(u2_reg);
                    mul_tag_in.kind = KIND_B1;
                end
                STEP_T2U:
                begin
                    mul_a = MA'(t2_reg);
                    mul_b = MB'(u_val);
                    mul_tag_in.kind = KIND_B2;
                end
                STEP_T2T:
                begin
                    mul_a = MA'(t2_reg);
                    mul_b = MB'(t_reg);
                    mul_tag_in.kind = KIND_B3;
                end
                default:
                begin
                    mul_tag_in.kind = KIND_NONE;
                end
            endcase
        end
        else if (state_reg == ST_DOT)
        begin
            mul_a           = MA'(b_reg[k_reg]);
            mul_b           = MB'(rd_coord);
            mul_tag_in.kind = KIND_ACC;
            mul_tag_in.axis = ax_reg;
        end
    end

    cbz_mul #(
        .A_WIDTH (MA),
        .B_WIDTH (MB)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .tag_in   (mul_tag_in),
        .prod_reg (prod),
        .tag_reg  (prod_tag)
    );

    // basis products are nonnegative: >> F is a plain slice
    assign prod_shr = prod[2*F:F];
    assign prod_x3  = (BW+2)'(prod_shr) + ((BW+2)'(prod_shr) << 1);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        ax_next    = ax_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_UU;
                k_next    = '0;
                ax_next   = '0;
                if (eval_acc)
                begin
                    state_next = seg_ok ? ST_BASIS : ST_OUT;
                end
            end
            ST_BASIS:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_T2T)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (ax_reg == AXIS_LAST)
                begin
                    ax_next = '0;
                    k_next  = k_reg + 2'd1;
                    if (k_reg == POINT_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    ax_next = ax_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            ax_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            ax_reg    <= ax_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // ---------------------------------------------------------------
    // word latch, basis capture, accumulation
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (eval_acc)
        begin
            t_reg      <= t_frac;
            base_reg   <= base_ext[AW-1:0];
            upd_reg    <= seg_ok;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        case (prod_tag.kind)
            KIND_U2:  u2_reg   <= prod_shr;
            KIND_T2:  t2_reg   <= prod_shr;
            KIND_B0:  b_reg[0] <= prod_shr;
            KIND_B1:  b_reg[1] <= prod_x3[BW-1:0];
            KIND_B2:  b_reg[2] <= prod_x3[BW-1:0];
            KIND_B3:  b_reg[3] <= prod_shr;
            KIND_ACC: acc_reg[prod_tag.axis] <=
                          acc_reg[prod_tag.axis] + $signed(prod[ACCW-1:0]);
            default:  ;
        endcase
    end

    // ---------------------------------------------------------------
    // floor shift and saturation into the held target
    // ---------------------------------------------------------------
    logic signed [CW-1:0] sat_val [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_sat
        logic signed [ACCW-1:0] shr;
        logic [ACCW-CW:0]       upper;

        assign shr   = acc_reg[g] >>> F;
        assign upper = shr[ACCW-1:CW-1];
        assign sat_val[g] = ((&upper) || !(|upper)) ? shr[CW-1:0] :
                            (shr[ACCW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg[0] <= '0;
            held_reg[1] <= '0;
            held_reg[2] <= '0;
        end
        else if (state_reg == ST_FIN)
        begin
            held_reg[0] <= sat_val[0];
            held_reg[1] <= sat_val[1];
            held_reg[2] <= sat_val[2];
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_x_reg   <= held_reg[0];
            out_y_reg   <= held_reg[1];
            out_z_reg   <= held_reg[2];
            out_upd_reg <= upd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign target_x  = out_x_reg;
    assign target_y  = out_y_reg;
    assign target_z  = out_z_reg;
    assign updated   = out_upd_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `CBZ_ASSERT_NEXT(a_held_only_in_fin, state_reg != ST_FIN,
        $stable(held_reg[0]) && $stable(held_reg[1]) && $stable(held_reg[2]),
        "held target changed outside the saturate step")

    `CBZ_ASSERT_IMPLY(a_acc_window, prod_tag.kind == KIND_ACC,
        state_reg == ST_DOT || state_reg == ST_DRAIN,
        "coordinate product landed outside the dot phase")

    `CBZ_ASSERT_IMPLY(a_missing_no_math, state_reg == ST_BASIS || state_reg == ST_DOT,
        upd_reg, "missing segment entered the arithmetic")

    `CBZ_ASSERT_NEXT(a_out_load_src, out_free && state_reg != ST_OUT,
        !out_valid_reg, "result register loaded outside the output step")

endmodule

// ===== dv/cubic_bezier_segment_eval_tb.sv =====
// Self-checking testbench for cubic_bezier_segment_eval: directed table, then random phases.
// Depends on cbz_pkg and the cubic_bezier_segment_eval RTL; needs nothing else.
`timescale 1ns / 1ps

module cubic_bezier_segment_eval_tb;
    import cbz_pkg::*;

    localparam int COORD_W    = 24;
    localparam int FRAC       = 16;
    localparam int NPTS       = 64;
    localparam int CMAX       = 8388607;
    localparam int CMIN       = -8388608;
    // margin for an evaluate to finish before a config write
    localparam int SETTLE_CYC = 40;
    localparam int HOLD_CYC   = 400;
    localparam int PH_WORDS   = 246;
    localparam int LIMIT_CYC  = 600000;

    // one input word, field for field as on the ports
    typedef struct packed {
        logic                      op;
        logic [POINT_INDEX_W-1:0]  point_index;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [SEG_W-1:0]          seg;
        logic [FRAC-1:0]           t;
    } word_t;

    // one output word
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      upd;
    } result_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    // directed row; ex/ey/ez/eupd are used only where typed is set
    typedef struct {
        row_kind_t kind;
        int        cnt;
        logic      op;
        int        idx;
        int        px, py, pz;
        int        seg;
        int        t;
        bit        typed;
        int        ex, ey, ez;
        bit        eupd;
    } dir_row_t;

    localparam int N_DIR = 24;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [COUNT_W-1:0]        cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      op = OP_WRITE;
    logic [POINT_INDEX_W-1:0]  point_index = '0;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic signed [COORD_W-1:0] point_z = '0;
    logic [SEG_W-1:0]          seg_index = '0;
    logic [FRAC-1:0]           t_frac = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic                      updated;

    // predictor state: its own copy of the point store, held target and point count
    logic signed [COORD_W-1:0] pt_store [NPTS][3];
    bit                        pt_written [NPTS];
    logic signed [COORD_W-1:0] held_tgt [3];
    logic [COUNT_W-1:0]        mdl_count;

    result_t     target_q [$];   // expected targets, oldest first
    word_t       plan_q [$];     // queued well-formed load/evaluate sequence
    result_t     want_r;
    int          n_bad = 0;
    int unsigned n_cycles = 0;
    int          send_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_rx = 1'b0;

    dir_row_t    dir_rows [N_DIR];

    cubic_bezier_segment_eval u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .seg_index   (seg_index),
        .t_frac      (t_frac),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .updated     (updated)
    );

    always #10 clk = ~clk;

    // Hard stop; generous against the slowest legal run.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= LIMIT_CYC)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall per cycle, or solid stall during the hold-off.
    always @(negedge clk)
        out_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct);

    // Long receiver hold-off, counted here while the sender keeps offering words.
    initial
    begin
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_rx = 1'b0;
    end

    // Output checker: every accepted word against the oldest expected target.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (target_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d upd=%0b",
                             target_x, target_y, target_z, updated);
            end
            else
            begin
                want_r = target_q.pop_front();
                if (target_x !== want_r.x || target_y !== want_r.y ||
                    target_z !== want_r.z || updated !== want_r.upd)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d upd=%0b, got x=%0d y=%0d z=%0d upd=%0b",
                                 want_r.x, want_r.y, want_r.z, want_r.upd,
                                 target_x, target_y, target_z, updated);
                end
            end
        end
    end

    // Predictor. A write stores the point, no result. An evaluate of a segment whose four
    // points lie below the (capped) point count recomputes the held target from the cubic
    // Bernstein weights; a missing segment keeps it. Both return the held target.
    function automatic bit apply_word(input word_t w, output result_t r);
        longint unsigned tf, uf, u2, t2;
        longint          wt [4];
        longint          acc;
        int              base, eff, a, k;
        r = '0;
        if (w.op == OP_WRITE)
        begin
            pt_store[w.point_index][0] = w.px;
            pt_store[w.point_index][1] = w.py;
            pt_store[w.point_index][2] = w.pz;
            pt_written[w.point_index]  = 1'b1;
            return 1'b0;
        end
        base = 4 * int'(w.seg);
        eff  = (int'(mdl_count) > NPTS) ? NPTS : int'(mdl_count);
        if (base + 4 <= eff)
        begin
            tf = 64'(w.t);
            uf = (64'd1 << FRAC) - tf;
            u2 = (uf * uf) >> FRAC;
            t2 = (tf * tf) >> FRAC;
            wt[0] = longint'((u2 * uf) >> FRAC);
            wt[1] = longint'(3 * ((tf * u2) >> FRAC));
            wt[2] = longint'(3 * ((t2 * uf) >> FRAC));
            wt[3] = longint'((t2 * tf) >> FRAC);
            for (a = 0; a < 3; a++)
            begin
                acc = 0;
                for (k = 0; k < 4; k++)
                    acc += wt[k] * longint'(pt_store[POINT_INDEX_W'(base + k)][a]);
                acc = acc >>> FRAC;   // floor toward minus infinity
                if (acc > CMAX)
                    acc = longint'(CMAX);
                else if (acc < CMIN)
                    acc = longint'(CMIN);
                held_tgt[a] = acc[COORD_W-1:0];
            end
            r.upd = 1'b1;
        end
        r.x = held_tgt[0];
        r.y = held_tgt[1];
        r.z = held_tgt[2];
        return 1'b1;
    endfunction

    // Coordinates lean on the extremes and on small magnitudes.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return COORD_W'(CMAX);
        if (sel == 1)
            return COORD_W'(CMIN);
        if (sel == 2)
            return COORD_W'($urandom_range(1023) - 512);
        return COORD_W'($urandom);
    endfunction

    function automatic logic [FRAC-1:0] rand_frac();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel == 2)
            return 16'd1;
        return FRAC'($urandom);
    endfunction

    // Next random word. Mostly load-then-evaluate sequences and evaluates of existing
    // segments; the rest is stray writes and missing segments. A live segment with an
    // unwritten slot gets that slot written first, so no unwritten entry is ever read.
    function automatic word_t next_word();
        word_t       w;
        int          eff, nseg, k, n_eval;
        int unsigned pick;
        bit          found;
        if (plan_q.size() != 0)
            return plan_q.pop_front();
        w.point_index = POINT_INDEX_W'($urandom_range(NPTS - 1));
        w.px   = rand_coord();
        w.py   = rand_coord();
        w.pz   = rand_coord();
        w.seg  = SEG_W'($urandom_range(15));
        w.t    = rand_frac();
        eff    = (int'(mdl_count) > NPTS) ? NPTS : int'(mdl_count);
        nseg   = eff / 4;
        pick   = $urandom_range(99);
        if (pick < 12)
        begin
            if (nseg > 0)
                w.seg = SEG_W'($urandom_range(nseg - 1));
            w.op = OP_WRITE;
            for (k = 0; k < 4; k++)
            begin
                w.point_index = POINT_INDEX_W'(4 * int'(w.seg) + k);
                w.px = rand_coord();
                w.py = rand_coord();
                w.pz = rand_coord();
                plan_q.push_back(w);
            end
            w.op   = OP_EVAL;
            n_eval = 1 + $urandom_range(3);
            for (k = 0; k < n_eval; k++)
            begin
                w.t = rand_frac();
                plan_q.push_back(w);
            end
            return plan_q.pop_front();
        end
        if (pick < 40)
        begin
            w.op = OP_WRITE;
            return w;
        end
        w.op = OP_EVAL;
        if (nseg > 0 && $urandom_range(3) != 0)
            w.seg = SEG_W'($urandom_range(nseg - 1));
        if (int'(w.seg) < nseg)
        begin
            found = 1'b0;
            for (k = 0; k < 4; k++)
            begin
                if (!found && !pt_written[POINT_INDEX_W'(4 * int'(w.seg) + k)])
                begin
                    found = 1'b1;
                    w.op = OP_WRITE;
                    w.point_index = POINT_INDEX_W'(4 * int'(w.seg) + k);
                end
            end
        end
        return w;
    endfunction

    // Offer one word at the falling edge, hold it until taken, then predict.
    task automatic send_word(input word_t w, input bit typed, input result_t typed_r);
        result_t pred;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w.op;
        point_index <= w.point_index;
        point_x     <= w.px;
        point_y     <= w.py;
        point_z     <= w.pz;
        seg_index   <= w.seg;
        t_frac      <= w.t;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (apply_word(w, pred))
            target_q.push_back(typed ? typed_r : pred);
    endtask

    // Stop offering, let every expected result out, then give the block time to settle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (target_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic set_point_count(input logic [COUNT_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        mdl_count  = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        word_t   w;
        result_t r_typed;
        int      i, p;
        int      ph_send [5];
        int      ph_rx   [5];
        int      ph_cnt  [5];

        // Directed table. Segment 0 is slots 0..3, segment 15 is slots 60..63.
        // At t = 0 the target is exactly the first control point of the segment.
        dir_rows = '{
            // reset count is zero: every segment missing, target still at reset zero
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  0,     1, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      15, 65535, 1, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 0,  CMAX, CMIN, 0,      0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 1,  CMIN, CMAX, -1,     0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 2,  256,  -256, CMAX,   0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 3,  -1,   1,    CMIN,   0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 60, CMIN, CMIN, CMIN,   0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 61, CMAX, CMAX, CMAX,   0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 62, CMIN, CMAX, 12345,  0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_WRITE, 63, CMAX, CMIN, -12345, 0,  0,     0, 0, 0, 0, 0},
            '{ROW_CFG,  64,  OP_EVAL,  0,  0,    0,    0,      0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  0,     1, CMAX, CMIN, 0, 1},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  65535, 0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  32768, 0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      15, 0,     1, CMIN, CMIN, CMIN, 1},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      15, 65535, 0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      15, 1,     0, 0, 0, 0, 0},
            // count not a multiple of four: only segment 0 is complete
            '{ROW_CFG,  7,   OP_EVAL,  0,  0,    0,    0,      0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  0,     1, CMAX, CMIN, 0, 1},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      1,  4660,  1, CMAX, CMIN, 0, 0},
            // count above the store size acts as a full store
            '{ROW_CFG,  127, OP_EVAL,  0,  0,    0,    0,      0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      15, 0,     1, CMIN, CMIN, CMIN, 1},
            // back to zero: target held from the last live evaluate
            '{ROW_CFG,  0,   OP_EVAL,  0,  0,    0,    0,      0,  0,     0, 0, 0, 0, 0},
            '{ROW_WORD, 0,   OP_EVAL,  0,  0,    0,    0,      0,  100,   1, CMIN, CMIN, CMIN, 0}
        };

        // random phases: sender idle %, receiver stall %, point count (-1: random)
        ph_send = '{0, 57, 0, 12, 0};
        ph_rx   = '{0, 0, 57, 12, 0};
        ph_cnt  = '{64, 127, -1, 5, 64};

        // predictor reset state
        for (i = 0; i < 3; i++)
            held_tgt[i] = '0;
        for (i = 0; i < NPTS; i++)
        begin
            pt_written[i] = 1'b0;
            pt_store[i][0] = '0;
            pt_store[i][1] = '0;
            pt_store[i][2] = '0;
        end
        mdl_count = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        for (i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_point_count(COUNT_W'(dir_rows[i].cnt));
            else
            begin
                w.op          = dir_rows[i].op;
                w.point_index = POINT_INDEX_W'(dir_rows[i].idx);
                w.px          = COORD_W'(dir_rows[i].px);
                w.py          = COORD_W'(dir_rows[i].py);
                w.pz          = COORD_W'(dir_rows[i].pz);
                w.seg         = SEG_W'(dir_rows[i].seg);
                w.t           = FRAC'(dir_rows[i].t);
                r_typed.x     = COORD_W'(dir_rows[i].ex);
                r_typed.y     = COORD_W'(dir_rows[i].ey);
                r_typed.z     = COORD_W'(dir_rows[i].ez);
                r_typed.upd   = dir_rows[i].eupd;
                send_word(w, dir_rows[i].typed, r_typed);
            end
        end

        // random part, one point count and idling profile per phase
        for (p = 0; p < 5; p++)
        begin
            set_point_count(COUNT_W'((ph_cnt[p] < 0) ? $urandom_range(127) : ph_cnt[p]));
            send_idle_pct = ph_send[p];
            rx_stall_pct  = ph_rx[p];
            // last phase: long receiver hold-off so the block backs up and stalls its input
            if (p == 4)
                hold_go = 1'b1;
            for (i = 0; i < PH_WORDS; i++)
            begin
                // sender pause mid-phase until everything outstanding has come out
                if (p == 4 && i == PH_WORDS / 2)
                    wait_drained();
                send_word(next_word(), 1'b0, '0);
            end
        end

        wait_drained();
        if (n_bad == 0 && target_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
